[hdl/sqou_pkg.sv]
// sqou_pkg: shared constants and types of the stack/queue operation unit
// opcodes, error codes, register indexes and the result record
// no dependencies
package sqou_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int OPCODE_W = 3;
	localparam int ERR_W    = 3;
	localparam int PORT_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [OPCODE_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PRINT = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SWAP  = 3'd4;

	localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
	localparam logic [ERR_W-1:0] ERR_PUSH_USAGE = 3'd1;
	localparam logic [ERR_W-1:0] ERR_PEEK_EMPTY = 3'd2;
	localparam logic [ERR_W-1:0] ERR_POP_EMPTY  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_SWAP_SHORT = 3'd4;
	localparam logic [ERR_W-1:0] ERR_FULL       = 3'd5;

	localparam logic [ADDR_W-3:0] REG_STACK_MODE = 1'd0;

	typedef struct packed {
		logic              is_error;
		logic [PORT_W-1:0] element_value;
		logic [ERR_W-1:0]  error_code;
		logic              last_result;
	} result_t;

endpackage

[hdl/stack_queue_operation_unit.sv]
// stack_queue_operation_unit: operand stack/queue of a bytecode interpreter
// push, pop and ignored items end in exec; peek and error results register after exec;
// swap reads then rewrites both slots; print reads elements in turn via one ram read port
// one item in flight at a time; a waiting result does not block the next transfer
// reset clears pointers, count, halt flag and the output register; ram contents stay undefined
module stack_queue_operation_unit #(
	parameter int STACK_DEPTH = sqou_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = sqou_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sqou_pkg::ADDR_W-1:0]        paddr,
	input  logic [sqou_pkg::DATA_W-1:0]        pwdata,
	output logic [sqou_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sqou_pkg::OPCODE_W-1:0]      opcode,
	input  logic signed [sqou_pkg::PORT_W-1:0] push_value,
	input  logic                               arg_valid,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               is_error,
	output logic signed [sqou_pkg::PORT_W-1:0] element_value,
	output logic [sqou_pkg::ERR_W-1:0]         error_code,
	output logic                               last_result
);

	localparam int IW = $clog2(STACK_DEPTH);

	logic                   stack_mode;
	sqou_pkg::result_t      result;
	logic                   wr_en;
	logic [IW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic [VALUE_WIDTH-1:0] rd_data;

	sqou_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.stack_mode (stack_mode)
	);

	sqou_seq #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.stack_mode (stack_mode),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.push_value (push_value),
		.arg_valid  (arg_valid),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	sqou_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign is_error      = result.is_error;
	assign element_value = result.element_value;
	assign error_code    = result.error_code;
	assign last_result   = result.last_result;

endmodule

[hdl/sqou_ram.sv]
// sqou_ram: generic single-port-write, single-port-read synchronous ram
// read data is registered and holds until the next read
// no dependencies
module sqou_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/sqou_regs.sv]
// sqou_regs: apb configuration register file (stack_mode)
// depends on sqou_pkg
module sqou_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sqou_pkg::ADDR_W-1:0] paddr,
	input  logic [sqou_pkg::DATA_W-1:0] pwdata,
	output logic [sqou_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output logic                        stack_mode
);

	logic stack_mode_q;
	logic hit;

	assign hit = (paddr[sqou_pkg::ADDR_W-1:2] == sqou_pkg::REG_STACK_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && hit) begin
			stack_mode_q <= pwdata[0];
		end
	end

	assign pready     = 1'b1;
	assign prdata     = hit ? {{(sqou_pkg::DATA_W-1){1'b0}}, stack_mode_q} : '0;
	assign stack_mode = stack_mode_q;

endmodule

[hdl/sqou_seq.sv]
// sqou_seq: operation sequencer with pointer state and output register
// reads, modifies and writes back the element ram; depends on sqou_pkg
module sqou_seq #(
	parameter int STACK_DEPTH = sqou_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = sqou_pkg::VALUE_WIDTH_DEF,
	localparam int IW = $clog2(STACK_DEPTH),
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          stack_mode,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sqou_pkg::OPCODE_W-1:0] opcode,
	input  logic signed [sqou_pkg::PORT_W-1:0] push_value,
	input  logic                          arg_valid,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sqou_pkg::result_t             result,
	output logic                          wr_en,
	output logic [IW-1:0]                 wr_addr,
	output logic [VALUE_WIDTH-1:0]        wr_data,
	output logic                          rd_en,
	output logic [IW-1:0]                 rd_addr,
	input  logic [VALUE_WIDTH-1:0]        rd_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ERR,
		ST_PEEK_WAIT,
		ST_PRINT_RD,
		ST_PRINT_DATA,
		ST_SWAP_B,
		ST_SWAP_C,
		ST_SWAP_D
	} state_t;

	state_t                        state_q;
	logic [sqou_pkg::OPCODE_W-1:0] op_q;
	logic [VALUE_WIDTH-1:0]        val_q;
	logic                          argv_q;
	logic [IW-1:0]                 top_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 k_q;
	logic                          halted_q;
	logic [VALUE_WIDTH-1:0]        tmp_q;
	logic [sqou_pkg::ERR_W-1:0]    err_q;
	logic                          out_valid_q;
	sqou_pkg::result_t             result_q;

	logic                          out_free;
	logic [IW-1:0]                 top_dec;
	logic [IW-1:0]                 top_inc;
	logic [IW-1:0]                 tail_slot;
	logic [IW-1:0]                 print_slot;
	logic [sqou_pkg::PORT_W-1:0]   rd_ext;
	logic                          print_last;

	function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (IW+1)'(STACK_DEPTH)) begin
			sum = sum - (IW+1)'(STACK_DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign out_free   = !out_valid_q || out_ready;
	assign top_dec    = (top_q == '0) ? IW'(STACK_DEPTH - 1) : top_q - IW'(1);
	assign top_inc    = slot_add(top_q, IW'(1));
	assign tail_slot  = slot_add(top_q, cnt_q[IW-1:0]);
	assign print_slot = slot_add(top_q, k_q[IW-1:0]);
	assign rd_ext     = sqou_pkg::PORT_W'($signed(rd_data));
	assign print_last = ((k_q + CW'(1)) == cnt_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// ram access
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = top_q;
		wr_data = val_q;
		rd_en   = 1'b0;
		rd_addr = top_q;
		case (state_q)
			ST_EXEC: begin
				if (!halted_q) begin
					case (op_q)
						sqou_pkg::OP_PUSH: begin
							if (argv_q && cnt_q != CW'(STACK_DEPTH)) begin
								wr_en = 1'b1;
								if (cnt_q == '0) begin
									wr_addr = '0;
								end else if (stack_mode) begin
									wr_addr = top_dec;
								end else begin
									wr_addr = tail_slot;
								end
							end
						end
						sqou_pkg::OP_PEEK: begin
							rd_en = (cnt_q != '0);
						end
						sqou_pkg::OP_SWAP: begin
							rd_en = (cnt_q >= CW'(2));
						end
						default: begin
						end
					endcase
				end
			end
			ST_PRINT_RD: begin
				rd_en   = 1'b1;
				rd_addr = print_slot;
			end
			ST_SWAP_B: begin
				rd_en   = 1'b1;
				rd_addr = top_inc;
			end
			ST_SWAP_C: begin
				wr_en   = 1'b1;
				wr_addr = top_q;
				wr_data = rd_data;
			end
			ST_SWAP_D: begin
				wr_en   = 1'b1;
				wr_addr = top_inc;
				wr_data = tmp_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			val_q       <= '0;
			argv_q      <= 1'b0;
			top_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			halted_q    <= 1'b0;
			tmp_q       <= '0;
			err_q       <= sqou_pkg::ERR_NONE;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						val_q   <= VALUE_WIDTH'(push_value);
						argv_q  <= arg_valid;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (!halted_q) begin
						case (op_q)
							sqou_pkg::OP_PUSH: begin
								if (!argv_q) begin
									err_q   <= sqou_pkg::ERR_PUSH_USAGE;
									state_q <= ST_ERR;
								end else if (cnt_q == CW'(STACK_DEPTH)) begin
									err_q   <= sqou_pkg::ERR_FULL;
									state_q <= ST_ERR;
								end else begin
									if (cnt_q == '0) begin
										top_q <= '0;
									end else if (stack_mode) begin
										top_q <= top_dec;
									end
									cnt_q <= cnt_q + CW'(1);
								end
							end
							sqou_pkg::OP_PRINT: begin
								k_q <= '0;
								if (cnt_q != '0) begin
									state_q <= ST_PRINT_RD;
								end
							end
							sqou_pkg::OP_PEEK: begin
								if (cnt_q == '0) begin
									err_q   <= sqou_pkg::ERR_PEEK_EMPTY;
									state_q <= ST_ERR;
								end else begin
									state_q <= ST_PEEK_WAIT;
								end
							end
							sqou_pkg::OP_POP: begin
								if (cnt_q == '0) begin
									err_q   <= sqou_pkg::ERR_POP_EMPTY;
									state_q <= ST_ERR;
								end else begin
									top_q <= top_inc;
									cnt_q <= cnt_q - CW'(1);
								end
							end
							sqou_pkg::OP_SWAP: begin
								if (cnt_q < CW'(2)) begin
									err_q   <= sqou_pkg::ERR_SWAP_SHORT;
									state_q <= ST_ERR;
								end else begin
									state_q <= ST_SWAP_B;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ERR: begin
					if (out_free) begin
						out_valid_q            <= 1'b1;
						result_q.is_error      <= 1'b1;
						result_q.element_value <= '0;
						result_q.error_code    <= err_q;
						result_q.last_result   <= 1'b1;
						halted_q               <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				ST_PEEK_WAIT: begin
					if (out_free) begin
						out_valid_q            <= 1'b1;
						result_q.is_error      <= 1'b0;
						result_q.element_value <= rd_ext;
						result_q.error_code    <= sqou_pkg::ERR_NONE;
						result_q.last_result   <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				ST_PRINT_RD: begin
					state_q <= ST_PRINT_DATA;
				end
				ST_PRINT_DATA: begin
					if (out_free) begin
						out_valid_q            <= 1'b1;
						result_q.is_error      <= 1'b0;
						result_q.element_value <= rd_ext;
						result_q.error_code    <= sqou_pkg::ERR_NONE;
						result_q.last_result   <= print_last;
						k_q                    <= k_q + CW'(1);
						state_q                <= print_last ? ST_IDLE : ST_PRINT_RD;
					end
				end
				ST_SWAP_B: begin
					tmp_q   <= rd_data;
					state_q <= ST_SWAP_C;
				end
				ST_SWAP_C: begin
					state_q <= ST_SWAP_D;
				end
				ST_SWAP_D: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
